>>> rtl/i2cmra_pkg.sv
package i2cmra_pkg;

  // Write buffer geometry
  localparam int WBUF_DEPTH = 16;
  localparam int WBUF_AW    = (WBUF_DEPTH > 1) ? $clog2(WBUF_DEPTH) : 1;
  localparam int WBUF_CW    = $clog2(WBUF_DEPTH + 1);

  // Operation codes
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_BEGIN = 2'd2;

  // Bus sequencer segments; byte segments also use a 2-bit half-bit offset
  typedef enum logic [13:0] {
    SEG_IDLE      = 14'b00000000000001,
    SEG_S_SETUP   = 14'b00000000000010,
    SEG_S_COND    = 14'b00000000000100,
    SEG_DEVW      = 14'b00000000001000,
    SEG_REGH      = 14'b00000000010000,
    SEG_REGL      = 14'b00000000100000,
    SEG_WDAT      = 14'b00000001000000,
    SEG_RS_LOW    = 14'b00000010000000,
    SEG_RS_HIGH   = 14'b00000100000000,
    SEG_RS_COND   = 14'b00001000000000,
    SEG_DEVR      = 14'b00010000000000,
    SEG_RDAT      = 14'b00100000000000,
    SEG_STOP_LOW  = 14'b01000000000000,
    SEG_STOP_HIGH = 14'b10000000000000
  } seg_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic        sda_in;
    logic [7:0]  data_byte;
    logic [7:0]  dev_addr;
    logic [15:0] reg_addr;
    logic        two_addr_bytes;
    logic        is_read;
    logic [15:0] byte_count;
  } item_t;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       busy;
    logic [7:0] rdata;
    logic       rvalid;
    logic       done;
    logic       nack;
  } res_t;

endpackage

>>> rtl/i2cmra_seq.sv
module i2cmra_seq (
  input  logic            clk,
  input  logic            rst,
  input  logic            step_en,
  input  i2cmra_pkg::item_t item,
  output i2cmra_pkg::res_t  res
);
  import i2cmra_pkg::*;

  localparam logic [WBUF_CW-1:0] WBUF_FULL = WBUF_CW'(WBUF_DEPTH);

  seg_t               seg, seg_next;
  logic [1:0]         off, off_next;
  logic [2:0]         bit_index, bit_index_next;
  logic [7:0]         shift_byte, shift_byte_next;
  logic [15:0]        bytes_left, bytes_left_next;
  logic [7:0]         saved_dev_addr, saved_dev_addr_next;
  logic [15:0]        saved_reg_addr, saved_reg_addr_next;
  logic [1:0]         saved_mode, saved_mode_next;
  logic [WBUF_CW-1:0] load_count, load_count_next;
  logic [WBUF_CW-1:0] send_index, send_index_next;
  logic               addr_nacked, addr_nacked_next;
  logic [7:0]         write_buffer [WBUF_DEPTH];
  logic [7:0]         wb_rdata;

  logic               wb_we;
  logic               in_byte;
  logic [15:0]        left_dec;
  logic [15:0]        nw_left;
  logic [WBUF_CW-1:0] nw_idx;
  logic [15:0]        load_ext;

  assign in_byte  = (seg == SEG_DEVW) || (seg == SEG_REGH) || (seg == SEG_REGL) ||
                    (seg == SEG_WDAT) || (seg == SEG_DEVR) || (seg == SEG_RDAT);
  assign left_dec = (bytes_left != 16'd0) ? bytes_left - 16'd1 : 16'd0;
  assign load_ext = 16'(load_count);

  // Next write byte: after a data byte the count and index move on in this step
  assign nw_idx  = (seg == SEG_WDAT) ? send_index + WBUF_CW'(1) : send_index;
  assign nw_left = (seg == SEG_WDAT) ? left_dec : bytes_left;

  always_comb begin
    seg_next            = seg;
    off_next            = off;
    bit_index_next      = bit_index;
    shift_byte_next     = shift_byte;
    bytes_left_next     = bytes_left;
    saved_dev_addr_next = saved_dev_addr;
    saved_reg_addr_next = saved_reg_addr;
    saved_mode_next     = saved_mode;
    load_count_next     = load_count;
    send_index_next     = send_index;
    addr_nacked_next    = addr_nacked;
    wb_we               = 1'b0;
    res.rdata           = 8'd0;
    res.rvalid          = 1'b0;
    res.done            = 1'b0;
    res.nack            = 1'b0;

    case (item.operation)
      OP_LOAD: begin
        if (seg == SEG_IDLE && load_count < WBUF_FULL) begin
          wb_we           = 1'b1;
          load_count_next = load_count + WBUF_CW'(1);
        end
      end
      OP_BEGIN: begin
        if (seg == SEG_IDLE) begin
          saved_dev_addr_next = item.dev_addr;
          saved_reg_addr_next = item.reg_addr;
          saved_mode_next     = {item.two_addr_bytes, item.is_read};
          addr_nacked_next    = 1'b0;
          if (item.is_read) begin
            bytes_left_next = item.byte_count;
          end else begin
            bytes_left_next = (item.byte_count < load_ext) ? item.byte_count : load_ext;
            send_index_next = '0;
            load_count_next = '0;
          end
          seg_next = SEG_S_SETUP;
        end
      end
      OP_TICK: begin
        if (seg != SEG_IDLE) begin
          if (in_byte) begin
            case (off)
              2'd1: begin
                shift_byte_next = {shift_byte[6:0], (seg == SEG_RDAT) & item.sda_in};
                if (bit_index == 3'd7) begin
                  bit_index_next = 3'd0;
                  off_next       = 2'd2;
                end else begin
                  bit_index_next = bit_index + 3'd1;
                  off_next       = 2'd0;
                end
              end
              2'd3: begin
                // ack phase ends: pick the following segment
                off_next       = 2'd0;
                bit_index_next = 3'd0;
                case (seg)
                  SEG_DEVW: begin
                    if (item.sda_in) begin
                      addr_nacked_next = 1'b1;
                      seg_next         = SEG_STOP_LOW;
                    end else if (saved_mode[1]) begin
                      seg_next        = SEG_REGH;
                      shift_byte_next = saved_reg_addr[15:8];
                    end else begin
                      seg_next        = SEG_REGL;
                      shift_byte_next = saved_reg_addr[7:0];
                    end
                  end
                  SEG_REGH: begin
                    seg_next        = SEG_REGL;
                    shift_byte_next = saved_reg_addr[7:0];
                  end
                  SEG_REGL, SEG_WDAT: begin
                    if (seg == SEG_WDAT) begin
                      send_index_next = nw_idx;
                      bytes_left_next = left_dec;
                    end
                    if (seg == SEG_REGL && saved_mode[0]) begin
                      seg_next = SEG_RS_LOW;
                    end else if (nw_left != 16'd0 && nw_idx < WBUF_FULL) begin
                      seg_next        = SEG_WDAT;
                      shift_byte_next = wb_rdata;
                    end else begin
                      seg_next = SEG_STOP_LOW;
                    end
                  end
                  SEG_DEVR: begin
                    if (bytes_left != 16'd0) begin
                      seg_next        = SEG_RDAT;
                      shift_byte_next = 8'd0;
                    end else begin
                      seg_next = SEG_STOP_LOW;
                    end
                  end
                  default: begin
                    res.rdata       = shift_byte;
                    res.rvalid      = 1'b1;
                    bytes_left_next = left_dec;
                    if (left_dec != 16'd0) begin
                      seg_next        = SEG_RDAT;
                      shift_byte_next = 8'd0;
                    end else begin
                      seg_next = SEG_STOP_LOW;
                    end
                  end
                endcase
              end
              default: off_next = off + 2'd1;
            endcase
          end else begin
            case (seg)
              SEG_S_SETUP: seg_next = SEG_S_COND;
              SEG_S_COND: begin
                seg_next        = SEG_DEVW;
                off_next        = 2'd0;
                bit_index_next  = 3'd0;
                shift_byte_next = {saved_dev_addr[7:1], 1'b0};
              end
              SEG_RS_LOW:  seg_next = SEG_RS_HIGH;
              SEG_RS_HIGH: seg_next = SEG_RS_COND;
              SEG_RS_COND: begin
                seg_next        = SEG_DEVR;
                off_next        = 2'd0;
                bit_index_next  = 3'd0;
                shift_byte_next = {saved_dev_addr[7:1], 1'b1};
              end
              SEG_STOP_LOW: seg_next = SEG_STOP_HIGH;
              default: begin
                seg_next         = SEG_IDLE;
                res.done         = 1'b1;
                res.nack         = addr_nacked;
                addr_nacked_next = 1'b0;
              end
            endcase
          end
        end
      end
      default: ;
    endcase

    // Pin levels after the step
    res.busy = (seg_next != SEG_IDLE);
    case (seg_next)
      SEG_DEVW, SEG_REGH, SEG_REGL, SEG_WDAT, SEG_DEVR, SEG_RDAT: begin
        res.scl = off_next[0];
        if (!off_next[1]) begin
          res.sda = (seg_next == SEG_RDAT) | shift_byte_next[7];
        end else begin
          res.sda = (seg_next == SEG_RDAT) ? (bytes_left_next <= 16'd1) : 1'b1;
        end
      end
      SEG_S_COND, SEG_RS_COND, SEG_STOP_HIGH: begin
        res.scl = 1'b1;
        res.sda = 1'b0;
      end
      SEG_RS_LOW: begin
        res.scl = 1'b0;
        res.sda = 1'b1;
      end
      SEG_STOP_LOW: begin
        res.scl = 1'b0;
        res.sda = 1'b0;
      end
      default: begin
        res.scl = 1'b1;
        res.sda = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seg            <= SEG_IDLE;
      off            <= 2'd0;
      bit_index      <= 3'd0;
      shift_byte     <= 8'd0;
      bytes_left     <= 16'd0;
      saved_dev_addr <= 8'd0;
      saved_reg_addr <= 16'd0;
      saved_mode     <= 2'd0;
      load_count     <= '0;
      send_index     <= '0;
      addr_nacked    <= 1'b0;
    end else if (step_en) begin
      seg            <= seg_next;
      off            <= off_next;
      bit_index      <= bit_index_next;
      shift_byte     <= shift_byte_next;
      bytes_left     <= bytes_left_next;
      saved_dev_addr <= saved_dev_addr_next;
      saved_reg_addr <= saved_reg_addr_next;
      saved_mode     <= saved_mode_next;
      load_count     <= load_count_next;
      send_index     <= send_index_next;
      addr_nacked    <= addr_nacked_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en && wb_we) begin
      write_buffer[load_count[WBUF_AW-1:0]] <= item.data_byte;
    end
    // next write byte fetched ahead; the buffer only changes while idle
    wb_rdata <= write_buffer[nw_idx[WBUF_AW-1:0]];
  end

endmodule

>>> rtl/i2c_master_register_access_core.sv
// I2C master for single register reads and writes. Each transfer on the input
// channel is one command: load a write byte into the 16-entry buffer, begin a
// transaction, or a bus tick that advances SCL/SDA by one half-bit phase and
// samples SDA. Every command yields exactly one result transfer carrying the
// pin levels after that step plus busy, received byte, done and address-NACK
// flags. A command moves from the input register through the sequencer logic
// into the result register; one command is taken every clock, and only a
// stalled result register holds the input side back. Writes send
// min(byte_count, loaded bytes) from the buffer and empty it; reads ACK every
// byte but the last. A NACK on the first device address ends the transaction
// with STOP and raises nack_error with done_res.
module i2c_master_register_access_core (
  input  logic        clk,
  input  logic        rst,
  // command channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic        sda_in,
  input  logic [7:0]  data_byte,
  input  logic [7:0]  dev_addr,
  input  logic [15:0] reg_addr,
  input  logic        two_addr_bytes,
  input  logic        is_read,
  input  logic [15:0] byte_count,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        scl_out,
  output logic        sda_out,
  output logic        busy_res,
  output logic [7:0]  read_data,
  output logic        read_valid,
  output logic        done_res,
  output logic        nack_error
);
  import i2cmra_pkg::*;

  logic  s1_valid;
  item_t s1_item;
  logic  out_take;
  logic  step_en;
  res_t  step_res;

  // Result register frees up when empty or drained this cycle
  assign out_take = !out_valid || !out_stall;
  // Command in the input register goes through the sequencer
  assign step_en  = s1_valid && out_take;
  assign in_stall = s1_valid && !out_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item.operation      <= operation;
      s1_item.sda_in         <= sda_in;
      s1_item.data_byte      <= data_byte;
      s1_item.dev_addr       <= dev_addr;
      s1_item.reg_addr       <= reg_addr;
      s1_item.two_addr_bytes <= two_addr_bytes;
      s1_item.is_read        <= is_read;
      s1_item.byte_count     <= byte_count;
    end
  end

  i2cmra_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .step_en (step_en),
    .item    (s1_item),
    .res     (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_take) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      scl_out    <= step_res.scl;
      sda_out    <= step_res.sda;
      busy_res   <= step_res.busy;
      read_data  <= step_res.rdata;
      read_valid <= step_res.rvalid;
      done_res   <= step_res.done;
      nack_error <= step_res.nack;
    end
  end

`ifndef SYNTHESIS
  // STOP completion leaves the bus released and the block idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> !busy_res && scl_out && sda_out)
    else $error("done with bus not released or still busy");

  a_nack_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && nack_error |-> done_res)
    else $error("address NACK reported without done");

  // A received byte is always followed by at least a STOP, never completion
  a_rdata_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && read_valid |-> busy_res && !done_res && !scl_out)
    else $error("read byte outside an active transaction");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid && out_stall)
    else $error("input stalled with room in the pipeline");

  // A held input command is processed in the cycle the result side frees up
  a_step_moves: assert property (@(posedge clk) disable iff (rst)
    step_en |=> out_valid)
    else $error("processed command did not reach the result register");
`endif

endmodule

>>> tb/i2c_master_register_access_core_tb.sv
`timescale 1ns / 100ps

module i2c_master_register_access_core_tb;
  import i2cmra_pkg::*;

  // Operation code 3 has no meaning to the block; it must change nothing.
  localparam logic [1:0] OP_NONE = 2'd3;

  // Bus sequencer positions. A byte occupies four consecutive codes, one per
  // half-bit quarter: SCL low with data, SCL high with data, SCL low for the
  // ack slot, SCL high for the ack slot.
  localparam logic [4:0] PH_IDLE      = 5'd0;
  localparam logic [4:0] PH_S_SETUP   = 5'd1;
  localparam logic [4:0] PH_S_COND    = 5'd2;
  localparam logic [4:0] PH_DEVW      = 5'd3;
  localparam logic [4:0] PH_REGH      = 5'd7;
  localparam logic [4:0] PH_REGL      = 5'd11;
  localparam logic [4:0] PH_WDAT      = 5'd15;
  localparam logic [4:0] PH_RS_LOW    = 5'd19;
  localparam logic [4:0] PH_RS_HIGH   = 5'd20;
  localparam logic [4:0] PH_RS_COND   = 5'd21;
  localparam logic [4:0] PH_DEVR      = 5'd22;
  localparam logic [4:0] PH_RDAT      = 5'd26;
  localparam logic [4:0] PH_STOP_LOW  = 5'd30;
  localparam logic [4:0] PH_STOP_HIGH = 5'd31;

  localparam int RUN_ITEMS    = 520;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 10;
  localparam int MAX_REPORTS  = 200;

  // Levels of a quiet bus with nothing pending.
  localparam res_t IDLE_LEVELS = '{1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  operation = OP_TICK;
  logic        sda_in = 1'b0;
  logic [7:0]  data_byte = 8'h00;
  logic [7:0]  dev_addr = 8'h00;
  logic [15:0] reg_addr = 16'h0000;
  logic        two_addr_bytes = 1'b0;
  logic        is_read = 1'b0;
  logic [15:0] byte_count = 16'h0000;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        scl_out;
  logic        sda_out;
  logic        busy_res;
  logic [7:0]  read_data;
  logic        read_valid;
  logic        done_res;
  logic        nack_error;

  i2c_master_register_access_core dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .operation      (operation),
    .sda_in         (sda_in),
    .data_byte      (data_byte),
    .dev_addr       (dev_addr),
    .reg_addr       (reg_addr),
    .two_addr_bytes (two_addr_bytes),
    .is_read        (is_read),
    .byte_count     (byte_count),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .scl_out        (scl_out),
    .sda_out        (sda_out),
    .busy_res       (busy_res),
    .read_data      (read_data),
    .read_valid     (read_valid),
    .done_res       (done_res),
    .nack_error     (nack_error)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shadow copy of the bus sequencer, advanced once per accepted command.
  // ---------------------------------------------------------------------------
  logic [4:0]  bus_phase = PH_IDLE;
  logic [2:0]  bit_cnt = 3'd0;
  logic [7:0]  shifter = 8'h00;
  logic [15:0] bytes_to_go = 16'h0000;
  logic [7:0]  cmd_dev = 8'h00;
  logic [15:0] cmd_reg = 16'h0000;
  logic        cmd_read = 1'b0;
  logic        cmd_two = 1'b0;
  logic [7:0]  wr_buf [WBUF_DEPTH];
  int unsigned wr_fill = 0;
  int unsigned wr_ptr = 0;
  logic        addr_nak = 1'b0;

  res_t pending_results [$];
  int   errors = 0;
  int   n_sent = 0;
  int   gap_pct = 7;
  int   stall_pct = 85;
  int   cycle_cnt = 0;

  function automatic bit is_byte_phase(logic [4:0] p);
    return (p >= PH_DEVW && p < PH_RS_LOW) || (p >= PH_DEVR && p < PH_STOP_LOW);
  endfunction

  function automatic logic [1:0] byte_offset(logic [4:0] p);
    logic [4:0] d;
    d = (p >= PH_DEVR) ? p - PH_DEVR : p - PH_DEVW;
    return d[1:0];
  endfunction

  task automatic begin_byte(input logic [4:0] base, input logic [7:0] value);
    bus_phase = base;
    shifter   = value;
    bit_cnt   = 3'd0;
  endtask

  // After the register address or a data byte of a write: next byte or STOP.
  task automatic next_write_byte();
    if (bytes_to_go != 0 && wr_ptr < WBUF_DEPTH) begin_byte(PH_WDAT, wr_buf[wr_ptr]);
    else bus_phase = PH_STOP_LOW;
  endtask

  task automatic advance_bus(input item_t it, output res_t r);
    logic [1:0] off;
    logic [4:0] base;
    r = '0;
    case (it.operation)
      OP_LOAD: begin
        // ignored while a transaction runs or once all entries hold data
        if (bus_phase == PH_IDLE && wr_fill < WBUF_DEPTH) begin
          wr_buf[wr_fill] = it.data_byte;
          wr_fill++;
        end
      end
      OP_BEGIN: begin
        if (bus_phase == PH_IDLE) begin
          cmd_dev  = it.dev_addr;
          cmd_reg  = it.reg_addr;
          cmd_read = it.is_read;
          cmd_two  = it.two_addr_bytes;
          addr_nak = 1'b0;
          if (it.is_read) begin
            bytes_to_go = it.byte_count;
          end else begin
            // write count is clamped to what was loaded; buffer starts over
            bytes_to_go = (it.byte_count < wr_fill) ? it.byte_count : 16'(wr_fill);
            wr_ptr  = 0;
            wr_fill = 0;
          end
          bus_phase = PH_S_SETUP;
        end
      end
      OP_TICK: begin
        if (bus_phase != PH_IDLE) begin
          if (is_byte_phase(bus_phase)) begin
            off  = byte_offset(bus_phase);
            base = bus_phase - off;
            case (off)
              2'd1: begin
                // SCL high on a data bit: only read bytes take SDA in
                shifter = {shifter[6:0], (base == PH_RDAT) ? it.sda_in : 1'b0};
                if (bit_cnt == 3'd7) begin
                  bit_cnt   = 3'd0;
                  bus_phase = bus_phase + 5'd1;
                end else begin
                  bit_cnt++;
                  bus_phase = bus_phase - 5'd1;
                end
              end
              2'd3: begin
                // end of the ack slot; only the write address ack matters
                case (base)
                  PH_DEVW: begin
                    if (it.sda_in) begin
                      addr_nak  = 1'b1;
                      bus_phase = PH_STOP_LOW;
                    end else if (cmd_two) begin
                      begin_byte(PH_REGH, cmd_reg[15:8]);
                    end else begin
                      begin_byte(PH_REGL, cmd_reg[7:0]);
                    end
                  end
                  PH_REGH: begin_byte(PH_REGL, cmd_reg[7:0]);
                  PH_REGL: begin
                    if (cmd_read) bus_phase = PH_RS_LOW;
                    else next_write_byte();
                  end
                  PH_WDAT: begin
                    wr_ptr++;
                    if (bytes_to_go != 0) bytes_to_go--;
                    next_write_byte();
                  end
                  PH_DEVR: begin
                    if (bytes_to_go != 0) begin_byte(PH_RDAT, 8'h00);
                    else bus_phase = PH_STOP_LOW;
                  end
                  default: begin
                    r.rdata  = shifter;
                    r.rvalid = 1'b1;
                    if (bytes_to_go != 0) bytes_to_go--;
                    if (bytes_to_go != 0) begin_byte(PH_RDAT, 8'h00);
                    else bus_phase = PH_STOP_LOW;
                  end
                endcase
              end
              default: bus_phase = bus_phase + 5'd1;
            endcase
          end else begin
            case (bus_phase)
              PH_S_SETUP:  bus_phase = PH_S_COND;
              PH_S_COND:   begin_byte(PH_DEVW, {cmd_dev[7:1], 1'b0});
              PH_RS_LOW:   bus_phase = PH_RS_HIGH;
              PH_RS_HIGH:  bus_phase = PH_RS_COND;
              PH_RS_COND:  begin_byte(PH_DEVR, {cmd_dev[7:1], 1'b1});
              PH_STOP_LOW: bus_phase = PH_STOP_HIGH;
              default: begin
                bus_phase = PH_IDLE;
                r.done    = 1'b1;
                r.nack    = addr_nak;
                addr_nak  = 1'b0;
              end
            endcase
          end
        end
      end
      default: ;
    endcase

    // pin levels of the position just reached
    if (is_byte_phase(bus_phase)) begin
      off   = byte_offset(bus_phase);
      base  = bus_phase - off;
      r.scl = off[0];
      if (!off[1]) r.sda = (base == PH_RDAT) ? 1'b1 : shifter[7];
      else r.sda = (base == PH_RDAT) ? (bytes_to_go <= 1) : 1'b1;  // ACK all but last
    end else begin
      case (bus_phase)
        PH_S_COND, PH_RS_COND, PH_STOP_HIGH: {r.scl, r.sda} = 2'b10;
        PH_RS_LOW:                           {r.scl, r.sda} = 2'b01;
        PH_STOP_LOW:                         {r.scl, r.sda} = 2'b00;
        default:                             {r.scl, r.sda} = 2'b11;
      endcase
    end
    r.busy = (bus_phase != PH_IDLE);
  endtask

  // ---------------------------------------------------------------------------
  // Command side. Drives at the rising edge, looks at in_stall mid-cycle so the
  // acceptance decision never races the block's own update.
  // ---------------------------------------------------------------------------
  task automatic send_item(input item_t it, input bit typed, input res_t want);
    res_t r;
    bit   took;
    // idle pattern: slow receiver first, then slow sender, then full speed
    if (n_sent < 200) begin
      gap_pct = 7;  stall_pct = 85;
    end else if (n_sent < 400) begin
      gap_pct = 85; stall_pct = 7;
    end else begin
      gap_pct = 0;  stall_pct = 0;
    end
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    {operation, sda_in, data_byte, dev_addr, reg_addr, two_addr_bytes, is_read,
     byte_count} <= it;
    do begin
      @(negedge clk);
      took = !in_stall;
      @(posedge clk);
    end while (!took);
    n_sent++;
    advance_bus(it, r);
    pending_results.push_back(typed ? want : r);
  endtask

  function automatic item_t random_item();
    logic [63:0] raw;
    raw = {$urandom(), $urandom()};
    return raw[$bits(item_t)-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random stall, and the check of each transfer mid-cycle.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_stall <= !rst && ($urandom_range(99) < stall_pct);
  end

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  always @(negedge clk) begin : result_check
    res_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t ns: result expected none, got scl %0b sda %0b busy %0b", $time,
                   scl_out, sda_out, busy_res);
      end else begin
        want = pending_results.pop_front();
        check_field("scl_out",    want.scl,    scl_out);
        check_field("sda_out",    want.sda,    sda_out);
        check_field("busy_res",   want.busy,   busy_res);
        check_field("read_data",  want.rdata,  read_data);
        check_field("read_valid", want.rvalid, read_valid);
        check_field("done_res",   want.done,   done_res);
        check_field("nack_error", want.nack,   nack_error);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Directed opening: quiet bus, the unused code, loads, then a read whose
  // device address is refused, with loads and begins thrown at it while busy.
  // ---------------------------------------------------------------------------
  typedef struct {
    item_t cmd;
    int    reps;
    bit    typed;
    res_t  want;
  } step_t;

  step_t opening [12] = '{
    '{'{OP_TICK,  1'b0, 8'h00, 8'h00, 16'h0000, 1'b0, 1'b0, 16'h0000}, 1, 1'b1, IDLE_LEVELS},
    '{'{OP_NONE,  1'b1, 8'hff, 8'hff, 16'hffff, 1'b1, 1'b1, 16'hffff}, 1, 1'b1, IDLE_LEVELS},
    '{'{OP_LOAD,  1'b0, 8'h00, 8'h00, 16'h0000, 1'b0, 1'b0, 16'h0000}, 1, 1'b1, IDLE_LEVELS},
    '{'{OP_LOAD,  1'b1, 8'hff, 8'h00, 16'h0000, 1'b0, 1'b0, 16'h0000}, 1, 1'b1, IDLE_LEVELS},
    '{'{OP_BEGIN, 1'b0, 8'h00, 8'hff, 16'hffff, 1'b1, 1'b1, 16'hffff}, 1, 1'b1,
      '{1'b1, 1'b1, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0}},
    // busy: load and begin are dropped, the unused code is a no-op
    '{'{OP_LOAD,  1'b0, 8'ha5, 8'h00, 16'h0000, 1'b0, 1'b0, 16'h0000}, 1, 1'b0, IDLE_LEVELS},
    '{'{OP_BEGIN, 1'b0, 8'h00, 8'h00, 16'h0000, 1'b0, 1'b0, 16'h0000}, 1, 1'b0, IDLE_LEVELS},
    '{'{OP_NONE,  1'b0, 8'h00, 8'h00, 16'h0000, 1'b0, 1'b0, 16'h0000}, 1, 1'b0, IDLE_LEVELS},
    // START and the write address, SDA left high
    '{'{OP_TICK,  1'b1, 8'h00, 8'h00, 16'h0000, 1'b0, 1'b0, 16'h0000}, 19, 1'b0, IDLE_LEVELS},
    // address not acknowledged: straight to STOP, error with done
    '{'{OP_TICK,  1'b1, 8'h00, 8'h00, 16'h0000, 1'b0, 1'b0, 16'h0000}, 1, 1'b1,
      '{1'b0, 1'b0, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0}},
    '{'{OP_TICK,  1'b0, 8'h00, 8'h00, 16'h0000, 1'b0, 1'b0, 16'h0000}, 1, 1'b1,
      '{1'b1, 1'b0, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0}},
    '{'{OP_TICK,  1'b0, 8'h00, 8'h00, 16'h0000, 1'b0, 1'b0, 16'h0000}, 1, 1'b1,
      '{1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b1, 1'b1}}
  };

  initial begin : stimulus
    item_t       it;
    int unsigned n_loads;
    bit          want_nack;
    want_nack = 1'b0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (opening[i])
      repeat (opening[i].reps) send_item(opening[i].cmd, opening[i].typed, opening[i].want);

    // Random part: mostly complete transactions with random content, run
    // tick by tick, with ignored commands sprinkled in while busy.
    while (n_sent < RUN_ITEMS || bus_phase != PH_IDLE) begin
      if (bus_phase == PH_IDLE) begin
        if ($urandom_range(9) == 0) begin
          it = random_item();
          it.operation = $urandom_range(1) ? OP_TICK : OP_NONE;
          send_item(it, 1'b0, IDLE_LEVELS);
        end
        // now and then overfill the buffer so the full case is hit
        n_loads = ($urandom_range(9) == 0) ? $urandom_range(15, 18) : $urandom_range(0, 4);
        repeat (n_loads) begin
          it = random_item();
          it.operation = OP_LOAD;
          send_item(it, 1'b0, IDLE_LEVELS);
        end
        it = random_item();
        it.operation = OP_BEGIN;
        want_nack = ($urandom_range(4) == 0);
        if (it.is_read) begin
          // long reads only when the address will be refused
          if (!want_nack) it.byte_count = 16'($urandom_range(0, 2));
        end else if (wr_fill > 4) begin
          it.byte_count = 16'($urandom_range(1, 2));
        end else begin
          case ($urandom_range(2))
            0:       it.byte_count = 16'($urandom_range(0, 3));
            1:       it.byte_count = 16'hffff;
            default: ;
          endcase
        end
        send_item(it, 1'b0, IDLE_LEVELS);
      end else if ($urandom_range(9) == 0) begin
        // dropped while busy
        it = random_item();
        it.operation = 2'($urandom_range(1, 3));
        send_item(it, 1'b0, IDLE_LEVELS);
      end else begin
        it = random_item();
        it.operation = OP_TICK;
        if (bus_phase == PH_DEVW + 5'd3) it.sda_in = want_nack;
        send_item(it, 1'b0, IDLE_LEVELS);
      end
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

>>> filelist.f
rtl/i2cmra_pkg.sv
rtl/i2cmra_seq.sv
rtl/i2c_master_register_access_core.sv
tb/i2c_master_register_access_core_tb.sv
